>>> hw/rtl/kdsl_pkg.sv
`timescale 1ns / 1ps

package kdsl_pkg;

   // Number of keys tracked by the block.
   localparam int NUM_KEYS = 3;
   // Keys with an input pin; keys above this see a released raw level.
   localparam int RAW_KEYS = 3;
   localparam int KEY_W    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

   localparam logic [15:0] DEBOUNCE_RESET = 16'd30;
   localparam logic [15:0] LONG_RESET     = 16'd1200;

   localparam logic CSR_DEBOUNCE_TIME   = 1'b0;
   localparam logic CSR_LONG_PRESS_TIME = 1'b1;

   localparam logic [1:0] EV_NONE  = 2'd0;
   localparam logic [1:0] EV_SHORT = 2'd1;
   localparam logic [1:0] EV_LONG  = 2'd2;

   typedef enum logic [1:0] {
      FUNC_POLL      = 2'd0,
      FUNC_TAKE_KEY  = 2'd1,
      FUNC_TAKE_WAKE = 2'd2,
      FUNC_EXT_WAKE  = 2'd3
   } kdsl_func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DEB,
      ST_LNG,
      ST_FIN
   } kdsl_state_type;

   // Commands from the sequencer to the key state bank.
   typedef struct packed {
      logic [KEY_W-1:0] sel;
      logic             deb_step;
      logic             lng_step;
      logic             take_key;
      logic             take_wake;
      logic             set_wake;
   } kdsl_cmd_type;

   // What the key state bank shows for the selected key and globally.
   typedef struct packed {
      logic [31:0] base;
      logic [1:0]  pend;
      logic        wake;
      logic [2:0]  mask;
   } kdsl_view_type;

endpackage

>>> hw/rtl/kdsl_cmp_unit.sv
`timescale 1ns / 1ps

// Shared elapsed-time compare: (now - base) modulo 2^32 against a 16-bit limit.
module kdsl_cmp_unit (
   input  logic [31:0] now_time,
   input  logic [31:0] base_time,
   input  logic [15:0] limit,
   output logic        reached
);
   logic [31:0] elapsed;

   assign elapsed = now_time - base_time;
   assign reached = (elapsed >= {16'd0, limit});
endmodule

>>> hw/rtl/kdsl_key_bank.sv
`timescale 1ns / 1ps

module kdsl_key_bank (
   input  logic                  clock,
   input  logic                  reset,
   input  kdsl_pkg::kdsl_cmd_type cmd,
   input  logic [31:0]           now_time,
   input  logic [2:0]            raw_levels,
   input  logic                  reached,
   output kdsl_pkg::kdsl_view_type view
);
   import kdsl_pkg::*;

   logic        stable_ff  [NUM_KEYS];
   logic        stable_in  [NUM_KEYS];
   logic        sampled_ff [NUM_KEYS];
   logic        sampled_in [NUM_KEYS];
   logic        long_ff    [NUM_KEYS];
   logic        long_in    [NUM_KEYS];
   logic [31:0] change_ff  [NUM_KEYS];
   logic [31:0] change_in  [NUM_KEYS];
   logic [31:0] start_ff   [NUM_KEYS];
   logic [31:0] start_in   [NUM_KEYS];
   logic [1:0]  pend_ff    [NUM_KEYS];
   logic [1:0]  pend_in    [NUM_KEYS];
   logic        wake_ff;
   logic        wake_in;

   logic [NUM_KEYS-1:0] raw_ext;
   logic                level;
   logic                changed;

   for (genvar k = 0; k < NUM_KEYS; k++) begin : g_raw
      if (k < RAW_KEYS) begin : g_pin
         assign raw_ext[k] = raw_levels[k];
      end else begin : g_nopin
         assign raw_ext[k] = 1'b0;
      end
   end

   assign level   = raw_ext[cmd.sel];
   assign changed = (level != sampled_ff[cmd.sel]);

   always_comb begin
      // In the debounce step a fresh raw change restarts the timer at now.
      if (cmd.deb_step) begin
         view.base = changed ? now_time : change_ff[cmd.sel];
      end else begin
         view.base = start_ff[cmd.sel];
      end
      view.pend = pend_ff[cmd.sel];
      view.wake = wake_ff;
      for (int j = 0; j < 3; j++) begin
         view.mask[j] = (j < NUM_KEYS) ? stable_ff[j] : 1'b0;
      end
   end

   always_comb begin
      stable_in  = stable_ff;
      sampled_in = sampled_ff;
      long_in    = long_ff;
      change_in  = change_ff;
      start_in   = start_ff;
      pend_in    = pend_ff;
      wake_in    = wake_ff;

      if (cmd.deb_step) begin
         sampled_in[cmd.sel] = level;
         if (changed) begin
            change_in[cmd.sel] = now_time;
         end
         if (reached && (stable_ff[cmd.sel] != level)) begin
            stable_in[cmd.sel] = level;
            if (level) begin
               start_in[cmd.sel] = now_time;
               long_in[cmd.sel]  = 1'b0;
               wake_in           = 1'b1;
            end else if (!long_ff[cmd.sel]) begin
               pend_in[cmd.sel] = EV_SHORT;
            end
         end
      end

      if (cmd.lng_step) begin
         if (stable_ff[cmd.sel] && !long_ff[cmd.sel] && reached) begin
            pend_in[cmd.sel] = EV_LONG;
            long_in[cmd.sel] = 1'b1;
            wake_in          = 1'b1;
         end
      end

      if (cmd.take_key) begin
         pend_in[cmd.sel] = EV_NONE;
      end
      if (cmd.take_wake) begin
         wake_in = 1'b0;
      end
      if (cmd.set_wake) begin
         wake_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_KEYS; k++) begin
            stable_ff[k]  <= 1'b0;
            sampled_ff[k] <= 1'b0;
            long_ff[k]    <= 1'b0;
            change_ff[k]  <= 32'd0;
            start_ff[k]   <= 32'd0;
            pend_ff[k]    <= EV_NONE;
         end
         wake_ff <= 1'b0;
      end else begin
         stable_ff  <= stable_in;
         sampled_ff <= sampled_in;
         long_ff    <= long_in;
         change_ff  <= change_in;
         start_ff   <= start_in;
         pend_ff    <= pend_in;
         wake_ff    <= wake_in;
      end
   end
endmodule

>>> hw/rtl/key_debounce_short_long_press.sv
`timescale 1ns / 1ps

// Channel  Direction  Transfer when           Payload
// req      in         req_valid & req_ready   func, now_time, raw_levels, key_index
// rsp      out        rsp_valid & rsp_ready   key_event, pressed_mask, wake
// csr      in         csr_write_en            csr_index, csr_write_data
//
// A poll runs, after the transfer, one debounce compare and one long-press compare
// per key, both on the single shared elapsed-time compare unit, then a final step
// that loads the result into the output register. Other items go from the
// transfer straight to the final step. Reset is synchronous and active high and
// restores every key's state, the wake flag and both timing registers. The block
// takes one item at a time; a result waiting in the output register holds the
// sequencer in its final state until it is transferred.
module key_debounce_short_long_press (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_now_time,
   input  logic [2:0]  req_raw_levels,
   input  logic [1:0]  req_key_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_key_event,
   output logic [2:0]  rsp_pressed_mask,
   output logic        rsp_wake,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [15:0] csr_write_data
);
   import kdsl_pkg::*;

   // Timing registers; the user must write them only while the block is idle, the block does not enforce it.
   logic [15:0] debounce_ff;
   logic [15:0] long_time_ff;

   // Sequencer state and the captured request.
   kdsl_state_type   state_ff;
   kdsl_state_type   state_in;
   logic [KEY_W-1:0] key_ff;
   logic [KEY_W-1:0] key_in;
   kdsl_func_type    func_ff;
   logic [31:0]      now_ff;
   logic [2:0]       raw_ff;
   logic             key_ok_ff;

   // Output register.
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic [1:0] rsp_event_ff;
   logic [2:0] rsp_mask_ff;
   logic       rsp_wake_ff;

   logic          req_xfer;
   logic          rsp_load;
   logic          reached;
   logic [15:0]   limit;
   kdsl_cmd_type  cmd;
   kdsl_view_type view;

   assign req_xfer = req_valid && req_ready;

   // The shared compare unit checks the debounce time in the debounce step
   // and the long-press time in the long step.
   assign limit = (state_ff == ST_DEB) ? debounce_ff : long_time_ff;

   kdsl_cmp_unit u_cmp (
      .now_time  (now_ff),
      .base_time (view.base),
      .limit     (limit),
      .reached   (reached)
   );

   kdsl_key_bank u_bank (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .now_time   (now_ff),
      .raw_levels (raw_ff),
      .reached    (reached),
      .view       (view)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff  <= DEBOUNCE_RESET;
         long_time_ff <= LONG_RESET;
      end else if (csr_write_en) begin
         if (csr_index == CSR_DEBOUNCE_TIME) begin
            debounce_ff <= csr_write_data;
         end else begin
            long_time_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         key_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         key_ff       <= key_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request capture and result payload; no reset needed.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         func_ff   <= kdsl_func_type'(req_func);
         now_ff    <= req_now_time;
         raw_ff    <= req_raw_levels;
         key_ok_ff <= (32'(req_key_index) < NUM_KEYS);
      end
      if (rsp_load) begin
         rsp_event_ff <= (func_ff == FUNC_TAKE_KEY && key_ok_ff) ? view.pend : EV_NONE;
         rsp_mask_ff  <= view.mask;
         rsp_wake_ff  <= (func_ff == FUNC_TAKE_WAKE) ? view.wake : 1'b0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      req_ready    = 1'b0;
      rsp_load     = 1'b0;
      cmd          = '0;
      cmd.sel      = key_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (kdsl_func_type'(req_func) == FUNC_POLL) begin
                  key_in   = '0;
                  state_in = ST_DEB;
               end else begin
                  key_in   = KEY_W'(req_key_index);
                  state_in = ST_FIN;
               end
            end
         end
         ST_DEB: begin
            cmd.deb_step = 1'b1;
            state_in     = ST_LNG;
         end
         ST_LNG: begin
            cmd.lng_step = 1'b1;
            if (32'(key_ff) == NUM_KEYS - 1) begin
               state_in = ST_FIN;
            end else begin
               key_in   = key_ff + 1'b1;
               state_in = ST_DEB;
            end
         end
         ST_FIN: begin
            // Finish only once the output register is free or being emptied.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load      = 1'b1;
               cmd.take_key  = (func_ff == FUNC_TAKE_KEY) && key_ok_ff;
               cmd.take_wake = (func_ff == FUNC_TAKE_WAKE);
               cmd.set_wake  = (func_ff == FUNC_EXT_WAKE);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_key_event    = rsp_event_ff;
   assign rsp_pressed_mask = rsp_mask_ff;
   assign rsp_wake         = rsp_wake_ff;
endmodule
